>>> sv/pip_pkg.sv
// Shared types for the point-in-polygon test block.
`default_nettype none

package pip_pkg;

   // Qualifies one vertex read as it leaves the vertex memory.
   typedef struct packed {
      logic valid;     // read data holds a vertex of the walk
      logic has_prev;  // an earlier vertex is held, so this read closes an edge
   } edge_ctl_type;

   // Status that the edge pipeline reports back to the sequencer.
   typedef struct packed {
      logic busy;        // some edge is still in flight
      logic flip_valid;  // an edge result is presented this cycle
      logic flip;        // that edge toggles the inside flag
   } edge_stat_type;

endpackage : pip_pkg

`default_nettype wire

>>> sv/pip_vtx_mem.sv
// Vertex table: one write port, one read port with registered read data.
`default_nettype none

module pip_vtx_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : pip_vtx_mem

`default_nettype wire

>>> sv/pip_edge_unit.sv
// Edge pipeline: differences, cross products, then the crossing decision.
`default_nettype none

module pip_edge_unit #(
   parameter int CW = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [CW-1:0]    qx,
   input  wire logic signed [CW-1:0]    qy,
   input  wire logic        [2*CW-1:0]  rd_data,
   input  wire pip_pkg::edge_ctl_type   ctl,
   output      pip_pkg::edge_stat_type  stat
);

   import pip_pkg::*;

   logic signed [CW-1:0]     xi, yi;
   logic signed [CW-1:0]     xj_ff, yj_ff;
   logic                     straddle_in;

   // Difference stage.
   logic                     d_valid_ff;
   logic                     d_straddle_ff;
   logic signed [CW:0]       d_a_ff, d_dy_ff, d_b_ff, d_c_ff;

   // Product stage.
   logic                     m_valid_ff;
   logic                     m_straddle_ff;
   logic                     m_dy_neg_ff;
   logic signed [2*CW+1:0]   m_p1_ff, m_p2_ff;

   // Decision stage.
   logic                     f_valid_ff;
   logic                     f_flip_ff;
   logic                     flip_in;

   assign xi = rd_data[CW-1:0];
   assign yi = rd_data[2*CW-1:CW];

   // The edge straddles the query when exactly one end lies at or above its y.
   assign straddle_in = (yi >= qy) != (yj_ff >= qy);

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         xj_ff <= xi;
         yj_ff <= yi;
      end
      d_straddle_ff <= straddle_in;
      d_a_ff  <= {qx[CW-1], qx} - {xi[CW-1], xi};
      d_dy_ff <= {yj_ff[CW-1], yj_ff} - {yi[CW-1], yi};
      d_b_ff  <= {xj_ff[CW-1], xj_ff} - {xi[CW-1], xi};
      d_c_ff  <= {qy[CW-1], qy} - {yi[CW-1], yi};
      m_straddle_ff <= d_straddle_ff;
      m_dy_neg_ff   <= d_dy_ff[CW];
      m_p1_ff <= d_a_ff * d_dy_ff;
      m_p2_ff <= d_b_ff * d_c_ff;
      f_flip_ff <= flip_in;
   end

   // A straddling edge never has a zero y difference, so the sign picks the
   // direction of the comparison.
   assign flip_in = m_straddle_ff &&
                    (m_dy_neg_ff ? (m_p1_ff >= m_p2_ff) : (m_p1_ff <= m_p2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= ctl.valid && ctl.has_prev;
         m_valid_ff <= d_valid_ff;
         f_valid_ff <= m_valid_ff;
      end
   end

   assign stat.busy       = d_valid_ff || m_valid_ff || f_valid_ff;
   assign stat.flip_valid = f_valid_ff;
   assign stat.flip       = f_flip_ff;

endmodule : pip_edge_unit

`default_nettype wire

>>> sv/point_in_polygon_test.sv
// Top level of the point-in-polygon test: sequencer, vertex memory and edge pipeline.
`default_nettype none

// Point-in-polygon test by the crossing-number rule. A load beat (operation 0)
// stores one vertex in the vertex memory at req_vertex_index; a slot at or
// beyond MAX_VERTICES is ignored. A test beat (operation 1) carries a query
// point and returns one rsp beat whose inside_res is 1 when the point lies
// inside the polygon formed by the first vertex_count vertices. The sequencer
// reads one vertex per cycle from the single read port of the vertex memory,
// starting with the last vertex and then running from the first to the last,
// so a test of n vertices makes n + 1 reads. These feed an edge pipeline of
// difference, product and decision stages that forms exact cross products.
// With a vertex count of zero the result is 0. The block works on one test at
// a time and holds req_stall high while it does; a finished result waits in
// the output register, so a new beat may be taken while the previous rsp beat
// is still stalled. Every vertex used by a test must have been loaded since
// reset. vertex_count must be written through the csr channel while the block
// is idle, which the block itself does not enforce; a value above MAX_VERTICES
// acts as MAX_VERTICES.
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 16,
   localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input channel.
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_operation,
   input  wire logic        [IDX_W-1:0]       req_vertex_index,
   input  wire logic signed [COORD_WIDTH-1:0] req_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_y,
   // Result channel.
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_inside_res,
   // Configuration channel.
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic        [CNT_W-1:0]       csr_vertex_count
);

   import pip_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      DRAIN,
      FINISH
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          left_ff;
   logic [IDX_W-1:0]          addr_ff;
   logic                      first_ff;
   logic                      inside_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_inside_ff;
   logic signed [COORD_WIDTH-1:0] qx_ff, qy_ff;
   edge_ctl_type              rd_ctl_ff;
   edge_stat_type             stat;

   logic                      req_accept;
   logic                      wr_en;
   logic [2*COORD_WIDTH-1:0]  rd_data;

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Loads write straight into the memory; slots past the table are dropped.
   assign wr_en = req_accept && !req_operation &&
                  ({1'b0, req_vertex_index} < (IDX_W+1)'(MAX_VERTICES));

   // The vertex count is clamped to the table depth as it is written.
   assign count_in = (csr_vertex_count > CNT_W'(MAX_VERTICES)) ?
                     CNT_W'(MAX_VERTICES) : csr_vertex_count;

   pip_vtx_mem #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (2*COORD_WIDTH),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_y, req_x}),
      .rd_en   (state_ff == WALK),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   pip_edge_unit #(
      .CW (COORD_WIDTH)
   ) u_edge (
      .clock   (clock),
      .reset   (reset),
      .qx      (qx_ff),
      .qy      (qy_ff),
      .rd_data (rd_data),
      .ctl     (rd_ctl_ff),
      .stat    (stat)
   );

   // Sequencer. The walk reads the last vertex first so that the first edge
   // closes the polygon, then reads vertices from the first to the last. The
   // control word is registered as each read is issued, so it travels in step
   // with the registered read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ctl_ff    <= '0;
         inside_ff    <= 1'b0;
         first_ff     <= 1'b0;
         left_ff      <= '0;
         addr_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= count_in;
         end
         rd_ctl_ff.valid    <= (state_ff == WALK);
         rd_ctl_ff.has_prev <= !first_ff;
         // A beat taken while FINISH presents the next one is replaced below.
         if (rsp_valid_ff && !rsp_stall && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (stat.flip_valid && stat.flip) begin
            inside_ff <= !inside_ff;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_accept && req_operation) begin
                  qx_ff     <= req_x;
                  qy_ff     <= req_y;
                  inside_ff <= 1'b0;
                  if (count_ff == '0) begin
                     state_ff <= FINISH;
                  end else begin
                     addr_ff  <= IDX_W'(count_ff - 1'b1);
                     left_ff  <= count_ff;
                     first_ff <= 1'b1;
                     state_ff <= WALK;
                  end
               end
            end
            WALK: begin
               first_ff <= 1'b0;
               if (first_ff) begin
                  addr_ff <= '0;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
               if (left_ff == '0) begin
                  state_ff <= DRAIN;
               end else begin
                  left_ff <= left_ff - 1'b1;
               end
            end
            DRAIN: begin
               // Wait until the last edge has passed through the pipeline.
               if (!rd_ctl_ff.valid && !stat.busy) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= inside_ff;
                  state_ff      <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule : point_in_polygon_test

`default_nettype wire

>>> sv/pip_check.sv
// Port-level checker for the point-in-polygon test, bound to the top level.
`default_nettype none

module pip_check (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_operation,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_inside_res
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res))
      else $error("stalled rsp beat changed");

   // A test beat occupies the block, so no beat is taken in the next cycle.
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation |=> req_stall)
      else $error("input taken right after a test beat");

   // After a load beat the input is not stalled in the next cycle.
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_operation |=> !req_stall)
      else $error("input stalled after a load beat");

   // A new result only appears at the end of a test, while input was stalled.
   a_rsp_after_test: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp beat appeared without a test in progress");

endmodule : pip_check

bind point_in_polygon_test pip_check u_pip_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res)
);

`default_nettype wire
